/* rtl/dmsl_pkg.sv */
// shared types, register codes and widths for the dual motor slew limiter
`default_nettype none

package dmsl_pkg;

    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // register index, taken from paddr word bits
    typedef enum logic [1:0] {
        REG_UP_STEP    = 2'd0,
        REG_DOWN_STEP  = 2'd1,
        REG_STALE_LIM  = 2'd2
    } t_reg_idx;

    // request type carried with each input word
    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic [STEP_W-1:0] up_step;
        logic [STEP_W-1:0] down_step;
    } t_steps;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] left_level;
        logic signed [LEVEL_W-1:0] right_level;
        logic                      armed;
        logic [COUNT_W-1:0]        packet_number;
    } t_result;

endpackage

`default_nettype wire

/* rtl/dual_motor_slew_limiter_core.sv */
// top level of the dual motor slew limiter: config port, command store, lanes and merge
//
//  channel | direction | handshake        | word
//  --------+-----------+------------------+------------------------------------------
//  input   | in        | i_valid/o_ready  | req type, left/right target, arm, now ms
//  result  | out       | o_valid/i_ready  | left/right level, armed, packet number
//  config  | in        | psel/penable     | up step, down step, stale limit (APB)
//
// one input word per cycle while o_ready is high; each tick's result is registered
// both lanes and the stale check settle within the accepting cycle
// an output register plus a skid stage let input flow while a result waits;
// o_ready drops only when both hold a result
// synchronous active-low reset clears the stored command, levels and counter
`default_nettype none

module dual_motor_slew_limiter_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_req_type,
    input  wire logic signed [dmsl_pkg::LEVEL_W-1:0] i_left_target,
    input  wire logic signed [dmsl_pkg::LEVEL_W-1:0] i_right_target,
    input  wire logic                                i_arm_request,
    input  wire logic [dmsl_pkg::TIME_W-1:0]         i_now_ms,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [dmsl_pkg::LEVEL_W-1:0]      o_left_level,
    output logic signed [dmsl_pkg::LEVEL_W-1:0]      o_right_level,
    output logic                                     o_armed_out,
    output logic [dmsl_pkg::COUNT_W-1:0]             o_packet_number,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dmsl_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [dmsl_pkg::DATA_W-1:0]         pwdata,
    output logic [dmsl_pkg::DATA_W-1:0]              prdata,
    output logic                                     pready
);
    import dmsl_pkg::*;

    logic [STEP_W-1:0]         r_up_step;
    logic [STEP_W-1:0]         r_down_step;
    logic [STEP_W-1:0]         r_stale_lim;

    logic signed [LEVEL_W-1:0] r_left_goal;
    logic signed [LEVEL_W-1:0] r_right_goal;
    logic [TIME_W-1:0]         r_cmd_time;
    logic                      r_have_cmd;
    logic                      r_armed;
    logic [COUNT_W-1:0]        r_tick_count;

    t_reg_idx                  reg_idx;
    logic                      cfg_write;
    logic                      accept;
    logic                      tick;
    logic                      space;
    logic [TIME_W-1:0]         age;
    logic                      stale;
    logic signed [LEVEL_W-1:0] left_goal;
    logic signed [LEVEL_W-1:0] right_goal;
    logic signed [LEVEL_W-1:0] left_next;
    logic signed [LEVEL_W-1:0] right_next;
    t_steps                    steps;
    t_result                   result;

    // configuration port
    assign reg_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_step   <= STEP_W'(8);
            r_down_step <= STEP_W'(32);
            r_stale_lim <= STEP_W'(250);
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_UP_STEP:   r_up_step   <= pwdata[STEP_W-1:0];
                REG_DOWN_STEP: r_down_step <= pwdata[STEP_W-1:0];
                REG_STALE_LIM: r_stale_lim <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_UP_STEP:   prdata = DATA_W'(r_up_step);
            REG_DOWN_STEP: prdata = DATA_W'(r_down_step);
            REG_STALE_LIM: prdata = DATA_W'(r_stale_lim);
            default:       prdata = '0;
        endcase
    end

    // input side
    assign o_ready = space;
    assign accept  = i_valid && space;
    assign tick    = accept && (i_req_type == REQ_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_cmd   <= 1'b0;
            r_armed      <= 1'b0;
            r_left_goal  <= '0;
            r_right_goal <= '0;
            r_cmd_time   <= '0;
            r_tick_count <= '0;
        end else if (accept) begin
            if (i_req_type == REQ_COMMAND) begin
                r_have_cmd   <= 1'b1;
                r_armed      <= i_arm_request;
                r_left_goal  <= i_left_target;
                r_right_goal <= i_right_target;
                r_cmd_time   <= i_now_ms;
            end else begin
                r_tick_count <= r_tick_count + COUNT_W'(1);
            end
        end
    end

    // age wraps modulo 2^32
    assign age        = i_now_ms - r_cmd_time;
    assign stale      = !r_have_cmd || (age > TIME_W'(r_stale_lim));
    assign left_goal  = stale ? '0 : r_left_goal;
    assign right_goal = stale ? '0 : r_right_goal;

    assign steps.up_step   = r_up_step;
    assign steps.down_step = r_down_step;

    dmsl_lane u_lane_left (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (tick),
        .i_goal       (left_goal),
        .i_steps      (steps),
        .o_next_level (left_next)
    );

    dmsl_lane u_lane_right (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (tick),
        .i_goal       (right_goal),
        .i_steps      (steps),
        .o_next_level (right_next)
    );

    dmsl_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (tick),
        .i_left_level    (left_next),
        .i_right_level   (right_next),
        .i_armed         (r_armed),
        .i_packet_number (r_tick_count),
        .o_space         (space),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result        (result)
    );

    assign o_left_level    = result.left_level;
    assign o_right_level   = result.right_level;
    assign o_armed_out     = result.armed;
    assign o_packet_number = result.packet_number;

endmodule

`default_nettype wire

/* rtl/dmsl_lane.sv */
// one slew limiter lane: holds a drive level and moves it toward its goal
`default_nettype none

module dmsl_lane (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_advance,
    input  wire logic signed [dmsl_pkg::LEVEL_W-1:0] i_goal,
    input  wire dmsl_pkg::t_steps                  i_steps,
    output logic signed [dmsl_pkg::LEVEL_W-1:0]    o_next_level
);
    import dmsl_pkg::*;

    localparam int unsigned MAG_W   = LEVEL_W + 1;
    localparam int unsigned DELTA_W = LEVEL_W + 2;

    logic signed [LEVEL_W-1:0] r_level;
    logic signed [LEVEL_W-1:0] n_level;

    logic [MAG_W-1:0]          goal_mag;
    logic [MAG_W-1:0]          level_mag;
    logic                      fast;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] limit;
    logic signed [DELTA_W-1:0] clamped;
    logic signed [DELTA_W-1:0] sum;

    always_comb begin
        goal_mag  = i_goal[LEVEL_W-1]  ? MAG_W'(-MAG_W'(signed'(i_goal)))
                                       : MAG_W'(i_goal);
        level_mag = r_level[LEVEL_W-1] ? MAG_W'(-MAG_W'(signed'(r_level)))
                                       : MAG_W'(r_level);
        // shrinking, or the sign goes through zero
        fast = (goal_mag < level_mag)
            || (((i_goal > 0) != (r_level > 0)) && (r_level != '0));
        limit = fast ? DELTA_W'(i_steps.down_step) : DELTA_W'(i_steps.up_step);
        delta = DELTA_W'(i_goal) - DELTA_W'(r_level);
        if (delta > limit) begin
            clamped = limit;
        end else if (delta < -limit) begin
            clamped = -limit;
        end else begin
            clamped = delta;
        end
        sum     = DELTA_W'(r_level) + clamped;
        n_level = sum[LEVEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_advance) begin
            r_level <= n_level;
        end
    end

    assign o_next_level = n_level;

endmodule

`default_nettype wire

/* rtl/dmsl_merge.sv */
// merges the lane levels into one result word, with an output register and skid stage
`default_nettype none

module dmsl_merge (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire logic signed [dmsl_pkg::LEVEL_W-1:0] i_left_level,
    input  wire logic signed [dmsl_pkg::LEVEL_W-1:0] i_right_level,
    input  wire logic                                i_armed,
    input  wire logic [dmsl_pkg::COUNT_W-1:0]        i_packet_number,
    output logic                                     o_space,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output dmsl_pkg::t_result                        o_result
);
    import dmsl_pkg::*;

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result merged;
    logic    pop;

    always_comb begin
        merged.left_level    = i_left_level;
        merged.right_level   = i_right_level;
        merged.armed         = i_armed;
        merged.packet_number = i_packet_number;
    end

    assign pop = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= merged;
            end else begin
                r_skid <= merged;
            end
        end
    end

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire
